>>> hdl/assert_macros.svh
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define MFPR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define MFPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked on every edge, reset included.
`define MFPR_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/mfpr_pkg.sv
package mfpr_pkg;

  // Panel geometry
  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;
  localparam int ROWS    = PAGES * 8;
  localparam int DEPTH   = COLUMNS * PAGES;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(DEPTH);

  // Refresh stream: three command bytes, then the column bytes of the page
  localparam int CMD_COUNT = 3;
  localparam int POS_W     = $clog2(COLUMNS + CMD_COUNT);

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // Clip limits in the width of the input coordinates
  localparam logic [7:0] COL_MAX = 8'(COLUMNS - 1);
  localparam logic [7:0] ROW_MAX = 8'(ROWS - 1);

  typedef enum logic [1:0] {
    MODE_POINT   = 2'd0,
    MODE_FILL    = 2'd1,
    MODE_REFRESH = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic rd_fill;
    logic wr_fill;
    logic rd_refresh;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic empty;
    logic fill_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/mono_framebuffer_page_refresh_core.sv
// Channel | Handshake              | Payload
// --------+------------------------+----------------------------------------------
// input   | in_valid / in_stall    | in_mode, in_x, in_y, in_x_end, in_y_end,
//         |                        | in_pixel_value
// output  | out_valid / out_stall  | out_byte, out_is_data, out_frame_last
//
// A refresh item is a store read, then a load of the output register.
// A point write is a one-pixel fill; a fill latches its box, then does one
// read-modify-write (read, then write) per store byte it touches. Empty fills,
// out-of-range points and mode 3 are taken without leaving the idle state.
// After reset the store is cleared one byte a cycle, with in_stall high.
// A refresh result waits in the output register while writes go on; the next
// refresh item is taken, then holds in_stall high until the waiting byte transfers.
module mono_framebuffer_page_refresh_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_x,
  input  logic [7:0] in_y,
  input  logic [7:0] in_x_end,
  input  logic [7:0] in_y_end,
  input  logic       in_pixel_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_data,
  output logic       out_frame_last
);
  import mfpr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mfpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  mfpr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_mode        (in_mode),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_data    (out_is_data),
    .out_frame_last (out_frame_last)
  );

endmodule

>>> hdl/mfpr_ctrl.sv
module mfpr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_mode,
  input  mfpr_pkg::dp_status_t status,
  output logic                in_stall,
  output mfpr_pkg::ctrl_cmd_t  cmd
);
  import mfpr_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;
  mode_t  mode;

  assign mode   = mode_t'(in_mode);
  assign accept = in_valid && (state_r == ST_IDLE);

  // Take input only when idle
  assign in_stall = (state_r != ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_POINT, MODE_FILL: begin
              if (!status.empty) state_nxt = ST_FILL_RD;
            end
            MODE_REFRESH: state_nxt = ST_EMIT;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FILL_RD: state_nxt = ST_FILL_WR;
      ST_FILL_WR: begin
        state_nxt = status.fill_last ? ST_IDLE : ST_FILL_RD;
      end
      ST_EMIT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_POINT, MODE_FILL: cmd.load = 1'b1;
            MODE_REFRESH:          cmd.rd_refresh = 1'b1;
            default:               cmd = '0;
          endcase
        end
      end
      ST_FILL_RD: cmd.rd_fill = 1'b1;
      ST_FILL_WR: cmd.wr_fill = 1'b1;
      ST_EMIT:    cmd.emit = status.out_free;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/mfpr_dp.sv
module mfpr_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mfpr_pkg::ctrl_cmd_t  cmd,
  output mfpr_pkg::dp_status_t status,
  input  logic [1:0]          in_mode,
  input  logic [7:0]          in_x,
  input  logic [7:0]          in_y,
  input  logic [7:0]          in_x_end,
  input  logic [7:0]          in_y_end,
  input  logic                in_pixel_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_is_data,
  output logic                out_frame_last
);
  import mfpr_pkg::*;

  localparam logic [PG_W-1:0]   PG_LAST  = PG_W'(PAGES - 1);
  localparam logic [POS_W-1:0]  POS_LAST = POS_W'(COLUMNS + CMD_COUNT - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

  // Frame store
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              mem_we;
  logic              mem_re;

  // Clearing pass
  logic [ADDR_W-1:0] clr_addr_r;

  // Fill walk
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] xe_r;
  logic [ROW_W-1:0] ys_r;
  logic [ROW_W-1:0] ye_r;
  logic [PG_W-1:0]  grp_r;
  logic             val_r;
  logic [PG_W-1:0]  grp_first;
  logic [PG_W-1:0]  grp_end;
  logic [PG_W-1:0]  fill_page;
  logic [ADDR_W-1:0] fill_addr;
  logic [2:0]       lo_bit;
  logic [2:0]       hi_bit;
  logic [7:0]       mask;
  logic [7:0]       fill_byte;

  // Refresh stream position
  logic [PG_W-1:0]  ref_page_r;
  logic [POS_W-1:0] ref_pos_r;
  logic [COL_W-1:0] ref_col;
  logic [ADDR_W-1:0] ref_addr;
  logic [7:0]       emit_byte;

  // Input corners, clipped
  logic [7:0] xe_sel;
  logic [7:0] ye_sel;
  logic [7:0] xe_clip;
  logic [7:0] ye_clip;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_is_data_r;
  logic       out_frame_last_r;

  // Clip the far corner; a point is a one-pixel fill
  always_comb begin
    xe_sel  = (mode_t'(in_mode) == MODE_POINT) ? in_x : in_x_end;
    ye_sel  = (mode_t'(in_mode) == MODE_POINT) ? in_y : in_y_end;
    xe_clip = (xe_sel > COL_MAX) ? COL_MAX : xe_sel;
    ye_clip = (ye_sel > ROW_MAX) ? ROW_MAX : ye_sel;
  end

  // Byte address and bit mask of the current fill step
  always_comb begin
    grp_first = PG_W'(ys_r >> 3);
    grp_end   = PG_W'(ye_r >> 3);
    fill_page = PG_LAST - grp_r;
    fill_addr = ADDR_W'(int'(fill_page) * COLUMNS + int'(col_r));
    lo_bit    = (grp_r == grp_first) ? ys_r[2:0] : 3'd0;
    hi_bit    = (grp_r == grp_end) ? ye_r[2:0] : 3'd7;
    mask      = (8'hFF >> lo_bit) & (8'hFF << (3'd7 - hi_bit));
    fill_byte = val_r ? (rdata_r | mask) : (rdata_r & ~mask);
  end

  // Refresh byte address and outgoing byte
  always_comb begin
    ref_col  = COL_W'(ref_pos_r - POS_W'(CMD_COUNT));
    ref_addr = ADDR_W'(int'(ref_page_r) * COLUMNS + int'(ref_col));
    case (ref_pos_r)
      POS_W'(0): emit_byte = CMD_PAGE_BASE + 8'(ref_page_r);
      POS_W'(1): emit_byte = CMD_COL_LOW;
      POS_W'(2): emit_byte = CMD_COL_HIGH;
      default:   emit_byte = rdata_r;
    endcase
  end

  // Memory port selection
  always_comb begin
    mem_re = cmd.rd_refresh | cmd.rd_fill;
    raddr  = cmd.rd_refresh ? ref_addr : fill_addr;
    mem_we = cmd.clr_step | cmd.wr_fill;
    waddr  = cmd.clr_step ? clr_addr_r : fill_addr;
    wdata  = cmd.clr_step ? 8'h00 : fill_byte;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_r <= mem[raddr];
  end

  // Advance the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  // Latch the fill box, then walk pages inside columns
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= COL_W'(in_x);
      xe_r  <= COL_W'(xe_clip);
      ys_r  <= ROW_W'(in_y);
      ye_r  <= ROW_W'(ye_clip);
      grp_r <= PG_W'(in_y >> 3);
      val_r <= in_pixel_value;
    end else if (cmd.wr_fill) begin
      if (grp_r == grp_end) begin
        grp_r <= grp_first;
        col_r <= col_r + COL_W'(1);
      end else begin
        grp_r <= grp_r + PG_W'(1);
      end
    end
  end

  // Advance the refresh position on each emitted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_page_r <= '0;
      ref_pos_r  <= '0;
    end else if (cmd.emit) begin
      if (ref_pos_r == POS_LAST) begin
        ref_pos_r  <= '0;
        ref_page_r <= (ref_page_r == PG_LAST) ? '0 : ref_page_r + PG_W'(1);
      end else begin
        ref_pos_r <= ref_pos_r + POS_W'(1);
      end
    end
  end

  // Output register: load on emit, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r       <= emit_byte;
      out_is_data_r    <= (ref_pos_r >= POS_W'(CMD_COUNT));
      out_frame_last_r <= (ref_pos_r == POS_LAST) && (ref_page_r == PG_LAST);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_is_data    = out_is_data_r;
  assign out_frame_last = out_frame_last_r;

  always_comb begin
    status.clr_last  = (clr_addr_r == ADDR_LAST);
    status.empty     = (in_x > xe_clip) || (in_y > ye_clip);
    status.fill_last = (col_r == xe_r) && (grp_r == grp_end);
    status.out_free  = !out_valid_r || !out_stall;
  end

endmodule

>>> hdl/mfpr_checker.sv
`include "assert_macros.svh"

module mfpr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_mode,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_is_data,
  input logic       out_frame_last
);
  import mfpr_pkg::*;

  logic refresh_xfer;

  assign refresh_xfer = in_valid && !in_stall && (mode_t'(in_mode) == MODE_REFRESH);

  // Hold a stalled result
  `MFPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // Input is stalled when reset is released, as the clearing pass starts
  `MFPR_ASSERT_ALWAYS(a_clear_stall, $rose(rst_n), in_stall, "input taken during clearing pass")

  // A refresh transfer into an empty output slot shows its byte after the store read and the output load
  `MFPR_ASSERT_SAME(a_refresh_lat, refresh_xfer && !out_valid, ##2 out_valid, "refresh byte late")

  // Frame end flag only on a data byte
  `MFPR_ASSERT_SAME(a_last_data, out_valid && out_frame_last, out_is_data, "frame end on command")

endmodule

bind mono_framebuffer_page_refresh_core mfpr_checker u_mfpr_checker (.*);

>>> verif/mono_framebuffer_page_refresh_core_tb.sv
module mono_framebuffer_page_refresh_core_tb;
  import mfpr_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 9;
  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int DRAIN_CYCLES  = 8;
  localparam int LIMIT_CYCLES  = 400000;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       frame_last;
  } panel_byte_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  x_end;
    logic [7:0]  y_end;
    logic        pixel_value;
    logic        typed;
    panel_byte_t want;
  } stim_t;

  localparam panel_byte_t NO_BYTE = '{8'h00, 1'b0, 1'b0};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_mode;
  logic [7:0] in_x;
  logic [7:0] in_y;
  logic [7:0] in_x_end;
  logic [7:0] in_y_end;
  logic       in_pixel_value;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_is_data;
  logic       out_frame_last;

  // Shadow copy of the frame and of the refresh scan position
  logic [7:0]  shadow_frame [DEPTH];
  int unsigned scan_page;
  int unsigned scan_pos;

  panel_byte_t panel_bytes_due [$];
  panel_byte_t head;
  int unsigned mismatches = 0;
  logic        sender_steady = 1'b0;
  logic        random_phase = 1'b0;
  int unsigned rx_cycles = 0;

  stim_t directed [DIRECTED_ROWS];

  mono_framebuffer_page_refresh_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .in_pixel_value(in_pixel_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_is_data   (out_is_data),
    .out_frame_last(out_frame_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Set or clear one pixel of the shadow frame; drop points off the panel
  function automatic void shade_pixel(int unsigned col, int unsigned row, logic on);
    int unsigned pg;
    logic [7:0]  mask;
    if (col > COLUMNS - 1 || row > ROWS - 1) return;
    pg   = PAGES - 1 - row / 8;
    mask = 8'h80 >> (row % 8);
    if (on) shadow_frame[pg * COLUMNS + col] |= mask;
    else shadow_frame[pg * COLUMNS + col] &= ~mask;
  endfunction

  // Clip the far corner to the panel, skip the fill when start passes end
  function automatic void fill_region(int unsigned x0, int unsigned y0,
                                      int unsigned x1, int unsigned y1, logic on);
    if (x1 > COLUMNS - 1) x1 = COLUMNS - 1;
    if (y1 > ROWS - 1) y1 = ROWS - 1;
    if (x0 > x1 || y0 > y1) return;
    for (int unsigned c = x0; c <= x1; c++)
      for (int unsigned r = y0; r <= y1; r++)
        shade_pixel(c, r, on);
  endfunction

  // Produce the next byte of the panel stream and advance the scan
  function automatic panel_byte_t next_panel_byte();
    panel_byte_t b;
    int unsigned col;
    b = NO_BYTE;
    case (scan_pos)
      0: b.value = CMD_PAGE_BASE + 8'(scan_page);
      1: b.value = CMD_COL_LOW;
      2: b.value = CMD_COL_HIGH;
      default: begin
        col          = scan_pos - CMD_COUNT;
        b.value      = shadow_frame[scan_page * COLUMNS + col];
        b.is_data    = 1'b1;
        b.frame_last = (col == COLUMNS - 1) && (scan_page == PAGES - 1);
      end
    endcase
    scan_pos++;
    if (scan_pos == CMD_COUNT + COLUMNS) begin
      scan_pos  = 0;
      scan_page = (scan_page + 1) % PAGES;
    end
    return b;
  endfunction

  // Apply an accepted item to the shadow state, queue the byte it yields
  function automatic void absorb_item(stim_t s);
    panel_byte_t b;
    case (s.mode)
      MODE_POINT: shade_pixel(32'(s.x), 32'(s.y), s.pixel_value);
      MODE_FILL: fill_region(32'(s.x), 32'(s.y), 32'(s.x_end), 32'(s.y_end),
                             s.pixel_value);
      MODE_REFRESH: begin
        b = next_panel_byte();
        panel_bytes_due.push_back(s.typed ? s.want : b);
      end
      default: ;
    endcase
  endfunction

  // Offer one item, hold it until it transfers, then predict
  task automatic offer_item(stim_t s);
    if (!sender_steady && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= s.mode;
    in_x           <= s.x;
    in_y           <= s.y;
    in_x_end       <= s.x_end;
    in_y_end       <= s.y_end;
    in_pixel_value <= s.pixel_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_item(s);
  endtask

  // Receiver: random stalls, one long hold-off, then a stretch with none
  always @(posedge clk) begin
    if (random_phase) rx_cycles++;
    if (random_phase && rx_cycles >= 100 && rx_cycles < 400) out_stall <= 1'b1;
    else if (random_phase && rx_cycles >= 2000 && rx_cycles < 4000) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 32);
  end

  // Compare each transferred byte with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (panel_bytes_due.size() == 0) begin
        $display("%0t: unexpected byte, expected none actual %02h", $time, out_byte);
        mismatches++;
      end else begin
        head = panel_bytes_due.pop_front();
        if (out_byte !== head.value) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, head.value, out_byte);
          mismatches++;
        end
        if (out_is_data !== head.is_data) begin
          $display("%0t: out_is_data expected %0b actual %0b",
                   $time, head.is_data, out_is_data);
          mismatches++;
        end
        if (out_frame_last !== head.frame_last) begin
          $display("%0t: out_frame_last expected %0b actual %0b",
                   $time, head.frame_last, out_frame_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_t       item;
    int unsigned sent;
    int unsigned pick;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_POINT;
    in_x           = 8'h00;
    in_y           = 8'h00;
    in_x_end       = 8'h00;
    in_y_end       = 8'h00;
    in_pixel_value = 1'b0;
    out_stall      = 1'b0;
    for (int i = 0; i < DEPTH; i++) shadow_frame[i] = 8'h00;
    scan_page = 0;
    scan_pos  = 0;

    directed = '{
      // blank frame right after reset: page 0 commands, then a zero column byte
      '{MODE_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, '{CMD_PAGE_BASE, 1'b0, 1'b0}},
      '{MODE_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, '{CMD_COL_LOW, 1'b0, 1'b0}},
      '{MODE_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, '{CMD_COL_HIGH, 1'b0, 1'b0}},
      '{MODE_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
      // corner points, then points off the panel
      '{MODE_POINT, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_BYTE},
      '{MODE_POINT, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1, 1'b0, NO_BYTE},
      '{MODE_POINT, 8'd128, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, NO_BYTE},
      '{MODE_POINT, 8'd0, 8'd64, 8'd0, 8'd0, 1'b1, 1'b0, NO_BYTE},
      '{MODE_POINT, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, NO_BYTE},
      // whole panel, clipped end
      '{MODE_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 1'b0, NO_BYTE},
      '{MODE_FILL, 8'd20, 8'd20, 8'd30, 8'd40, 1'b0, 1'b0, NO_BYTE},
      // start after end in x, then in y
      '{MODE_FILL, 8'd5, 8'd3, 8'd3, 8'd10, 1'b1, 1'b0, NO_BYTE},
      '{MODE_FILL, 8'd3, 8'd12, 8'd6, 8'd10, 1'b0, 1'b0, NO_BYTE},
      // start beyond the panel touches nothing
      '{MODE_FILL, 8'd200, 8'd70, 8'd255, 8'd255, 1'b0, 1'b0, NO_BYTE},
      '{MODE_FILL, 8'd10, 8'd10, 8'd10, 8'd10, 1'b0, 1'b0, NO_BYTE},
      '{MODE_POINT, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_BYTE},
      // unused mode
      '{MODE_NONE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_BYTE},
      '{MODE_NONE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, NO_BYTE},
      '{MODE_FILL, 8'd64, 8'd0, 8'd255, 8'd31, 1'b0, 1'b0, NO_BYTE},
      // writes above must show in the following data bytes
      '{MODE_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_BYTE},
      '{MODE_REFRESH, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, NO_BYTE},
      '{MODE_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_BYTE}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) offer_item(directed[i]);

    // Random traffic: mostly refresh, small fills, some noise; run past a frame wrap
    random_phase = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      sender_steady = (sent >= 500 && sent < 800);
      pick = $urandom_range(0, 99);
      item.x           = 8'($urandom);
      item.y           = 8'($urandom);
      item.x_end       = 8'($urandom);
      item.y_end       = 8'($urandom);
      item.pixel_value = 1'($urandom);
      item.typed       = 1'b0;
      item.want        = NO_BYTE;
      if (pick < 92) item.mode = MODE_REFRESH;
      else if (pick < 96) item.mode = MODE_POINT;
      else if (pick < 99) item.mode = MODE_FILL;
      else item.mode = MODE_NONE;
      if (item.mode == MODE_POINT && $urandom_range(0, 7) != 0) begin
        item.x = 8'($urandom_range(0, COLUMNS - 1));
        item.y = 8'($urandom_range(0, ROWS - 1));
      end
      if (item.mode == MODE_FILL && $urandom_range(0, 15) != 0) begin
        item.x     = 8'($urandom_range(0, COLUMNS - 1));
        item.y     = 8'($urandom_range(0, ROWS - 1));
        item.x_end = item.x + 8'($urandom_range(0, 7));
        item.y_end = item.y + 8'($urandom_range(0, 15));
        // occasionally swap the corners so start lies past end
        if ($urandom_range(0, 9) == 0) begin
          item.x_end = item.x;
          item.x     = item.x + 8'($urandom_range(1, 7));
        end
      end
      offer_item(item);
      sent++;
    end
    in_valid      <= 1'b0;
    sender_steady = 1'b0;

    // Drain outstanding bytes, then let the pipe settle
    while (panel_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("status: fail");
    $finish;
  end

endmodule
